FILE: sv/qpc_pkg.sv
// Package for the quadrature position counter.
// Holds widths, codes, the work-entry struct and the step decode functions.
// No dependencies.
package qpc_pkg;

   localparam int ENC_COUNT   = 4;
   localparam int IDX_W       = (ENC_COUNT > 1) ? $clog2(ENC_COUNT) : 1;
   localparam int FIELD_IDX_W = 2;
   localparam int POS_W       = 32;
   localparam int STEP_W      = 2;
   localparam int MASK_W      = 4;
   localparam int CSR_DATA_W  = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0]              pair_type;
   typedef logic signed [STEP_W-1:0] step_type;
   typedef logic signed [POS_W-1:0]  position_type;

   localparam step_type STEP_ZERO  = 2'sb00;
   localparam step_type STEP_PLUS  = 2'sb01;
   localparam step_type STEP_MINUS = 2'sb11;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REVERSE_MASK = 1'b0,
      REG_DECODE_MODE  = 1'b1
   } csr_reg_type;

   typedef enum logic {
      MODE_FULL = 1'b0,
      MODE_EDGE = 1'b1
   } decode_mode_type;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_LOAD,
      OP_SKIP
   } op_type;

   typedef struct packed {
      logic                  enable;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      op_type          op;
      logic [IDX_W-1:0] idx;
      pair_type        pair;
      logic            reverse;
      decode_mode_type mode;
      position_type    new_position;
   } work_type;

   function automatic pair_type gray_next(input pair_type p);
      pair_type n;
      unique case (p)
         2'b00:   n = 2'b01;
         2'b01:   n = 2'b11;
         2'b11:   n = 2'b10;
         default: n = 2'b00;
      endcase
      return n;
   endfunction

   function automatic step_type full_step(input pair_type prev, input pair_type cur);
      step_type s;
      if (gray_next(prev) == cur) begin
         s = STEP_PLUS;
      end else if (gray_next(cur) == prev) begin
         s = STEP_MINUS;
      end else begin
         s = STEP_ZERO;
      end
      return s;
   endfunction

   function automatic step_type edge_step(input pair_type prev, input pair_type cur);
      step_type s;
      if (cur[1] == prev[1]) begin
         s = STEP_ZERO;
      end else if (cur[1] != cur[0]) begin
         s = STEP_PLUS;
      end else begin
         s = STEP_MINUS;
      end
      return s;
   endfunction

endpackage

FILE: sv/qpc_if.sv
// Channel interfaces for the quadrature position counter.
// Request and response words with valid/ready; depends on qpc_pkg.
interface qpc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [qpc_pkg::FIELD_IDX_W-1:0] encoder_index;
   logic                          phase_a;
   logic                          phase_b;
   logic signed [qpc_pkg::POS_W-1:0] new_position;

   modport source (output valid, func, encoder_index, phase_a, phase_b, new_position,
                   input ready);
   modport sink (input valid, func, encoder_index, phase_a, phase_b, new_position,
                 output ready);
endinterface

interface qpc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [qpc_pkg::POS_W-1:0]  position_out;
   logic signed [qpc_pkg::STEP_W-1:0] step_taken;

   modport source (output valid, position_out, step_taken, input ready);
   modport sink (input valid, position_out, step_taken, output ready);
endinterface

FILE: sv/qpc_front.sv
// Front end: holds the configuration registers, accepts request words and
// classifies them into work entries. Depends on qpc_pkg and qpc_if.
module qpc_front (
   input  logic                  clock,
   input  logic                  reset,
   qpc_req_if.sink               req_chan,
   input  qpc_pkg::csr_write_type csr_write,
   output logic                  push_valid,
   output qpc_pkg::work_type     push_entry,
   input  logic                  push_ready
);

   logic [qpc_pkg::MASK_W-1:0] reverse_mask_ff, reverse_mask_in;
   qpc_pkg::decode_mode_type   decode_mode_ff, decode_mode_in;

   always_comb begin
      reverse_mask_in = reverse_mask_ff;
      decode_mode_in  = decode_mode_ff;
      if (csr_write.enable) begin
         unique case (qpc_pkg::csr_reg_type'(csr_write.index))
            qpc_pkg::REG_REVERSE_MASK: reverse_mask_in = csr_write.data;
            qpc_pkg::REG_DECODE_MODE:
               decode_mode_in = qpc_pkg::decode_mode_type'(csr_write.data[0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_mask_ff <= '0;
         decode_mode_ff  <= qpc_pkg::MODE_FULL;
      end else begin
         reverse_mask_ff <= reverse_mask_in;
         decode_mode_ff  <= decode_mode_in;
      end
   end

   always_comb begin
      push_entry.idx          = qpc_pkg::IDX_W'(req_chan.encoder_index);
      push_entry.pair         = {req_chan.phase_a, req_chan.phase_b};
      push_entry.reverse      = reverse_mask_ff[req_chan.encoder_index];
      push_entry.mode         = decode_mode_ff;
      push_entry.new_position = req_chan.new_position;
      if (32'(req_chan.encoder_index) >= qpc_pkg::ENC_COUNT) begin
         push_entry.op = qpc_pkg::OP_SKIP;
      end else if (req_chan.func) begin
         push_entry.op = qpc_pkg::OP_LOAD;
      end else begin
         push_entry.op = qpc_pkg::OP_SAMPLE;
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

FILE: sv/qpc_queue.sv
// Short work queue between front and back end.
// Two-entry register FIFO of work entries; depends on qpc_pkg.
module qpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  qpc_pkg::work_type push_entry,
   output logic              push_ready,
   output logic              pop_valid,
   output qpc_pkg::work_type pop_entry,
   input  logic              pop_ready
);

   qpc_pkg::work_type           entry_ff [qpc_pkg::QUEUE_DEPTH];
   logic [qpc_pkg::QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [qpc_pkg::QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [qpc_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        push;
   logic                        pop;

   assign push_ready = (32'(count_ff) != qpc_pkg::QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/qpc_back.sv
// Back end: per-encoder phase and position state, step decode, update and
// the response register. Depends on qpc_pkg and qpc_if.
module qpc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  qpc_pkg::work_type pop_entry,
   output logic              pop_ready,
   qpc_rsp_if.source         rsp_chan
);

   qpc_pkg::pair_type     last_phases_ff [qpc_pkg::ENC_COUNT];
   qpc_pkg::position_type position_ff [qpc_pkg::ENC_COUNT];
   logic                  out_valid_ff, out_valid_in;
   qpc_pkg::position_type rsp_position_ff, rsp_position_in;
   qpc_pkg::step_type     rsp_step_ff, rsp_step_in;
   qpc_pkg::pair_type     prev_pair;
   qpc_pkg::position_type pos_old;
   qpc_pkg::step_type     raw_step;
   qpc_pkg::step_type     dir_step;
   logic                  pop;

   assign pop_ready = !out_valid_ff || rsp_chan.ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      prev_pair = last_phases_ff[pop_entry.idx];
      pos_old   = position_ff[pop_entry.idx];
      unique case (pop_entry.mode)
         qpc_pkg::MODE_FULL: raw_step = qpc_pkg::full_step(prev_pair, pop_entry.pair);
         qpc_pkg::MODE_EDGE: raw_step = qpc_pkg::edge_step(prev_pair, pop_entry.pair);
      endcase
      dir_step = pop_entry.reverse ? -raw_step : raw_step;
      unique case (pop_entry.op)
         qpc_pkg::OP_SAMPLE: begin
            rsp_step_in     = dir_step;
            rsp_position_in = pos_old + {{(qpc_pkg::POS_W-qpc_pkg::STEP_W){dir_step[1]}},
                                         dir_step};
         end
         qpc_pkg::OP_LOAD: begin
            rsp_step_in     = qpc_pkg::STEP_ZERO;
            rsp_position_in = pop_entry.new_position;
         end
         default: begin
            rsp_step_in     = qpc_pkg::STEP_ZERO;
            rsp_position_in = '0;
         end
      endcase
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < qpc_pkg::ENC_COUNT; i++) begin
            last_phases_ff[i] <= '0;
            position_ff[i]    <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop && pop_entry.op == qpc_pkg::OP_SAMPLE) begin
            last_phases_ff[pop_entry.idx] <= pop_entry.pair;
            position_ff[pop_entry.idx]    <= rsp_position_in;
         end else if (pop && pop_entry.op == qpc_pkg::OP_LOAD) begin
            position_ff[pop_entry.idx] <= rsp_position_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_position_ff <= rsp_position_in;
         rsp_step_ff     <= rsp_step_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.position_out = rsp_position_ff;
   assign rsp_chan.step_taken   = rsp_step_ff;

   a_load_no_step: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.op == qpc_pkg::OP_LOAD |=> rsp_step_ff == qpc_pkg::STEP_ZERO)
      else $error("load word reported a nonzero step");

   a_load_value: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.op == qpc_pkg::OP_LOAD
      |=> rsp_position_ff == $past(pop_entry.new_position))
      else $error("load word did not return the loaded position");

   a_pair_stored: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.op == qpc_pkg::OP_SAMPLE
      |=> last_phases_ff[$past(pop_entry.idx)] == $past(pop_entry.pair))
      else $error("sample word did not update the remembered phases");

   a_step_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> rsp_step_ff != 2'sb10)
      else $error("illegal step code on response");

endmodule

FILE: sv/quadrature_position_counter.sv
// Quadrature position counter with four encoder channels, x4 or A-edge decode.
// Top level: front end, work queue and back end; depends on qpc_pkg and qpc_if.
//
// One word is accepted per clock while the response side is not stalled, and
// every word returns one response, held in the queue and then in the back end's
// response register. The rate is set by the back end's read-modify-write of the
// addressed encoder's phase pair and position; the two-entry queue lets the
// request side keep accepting, until full, while a response waits to be taken.
module quadrature_position_counter (
   input  logic                            clock,
   input  logic                            reset,
   qpc_req_if.sink                         req_chan,
   qpc_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [qpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qpc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   qpc_pkg::csr_write_type csr_write;
   logic                   push_valid;
   qpc_pkg::work_type      push_entry;
   logic                   push_ready;
   logic                   pop_valid;
   qpc_pkg::work_type      pop_entry;
   logic                   pop_ready;

   assign csr_write.enable = csr_write_enable;
   assign csr_write.index  = csr_index;
   assign csr_write.data   = csr_write_data;

   qpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_write  (csr_write),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   qpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   qpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
